[hw/rtl/svmc_pkg.sv]
package svmc_pkg;

    localparam int ACC_BITS_DEF = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_IDX_W    = 2;

    localparam int SAMPLE_MAX   = 32'h7fff;
    localparam int SAMPLE_MIN   = -32'sh8000;
    localparam int RING_LG_MIN  = 1;
    localparam int RING_LG_MAX  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_VOLUME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_8BIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_STEREO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE_LOG2 = 2'd3;

    localparam logic [8:0] MASTER_VOLUME_RST = 9'd256;
    localparam logic [4:0] RING_LG_RST       = 5'd14;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_ADD    = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] base_left;
        logic signed [31:0] base_right;
        logic signed [15:0] sample;
        logic [7:0]         vol_left;
        logic [7:0]         vol_right;
        logic               is_8bit;
    } t_cmd;

    typedef struct packed {
        logic [8:0] master_volume;
        logic       output_8bit;
        logic       output_stereo;
        logic [4:0] ring_size_log2;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_ACC,
        ST_EMIT_L,
        ST_EMIT_R
    } t_state;

    function automatic logic [15:0] ring_mask(input logic [4:0] lg);
        logic [4:0] lg_c;
        lg_c = lg;
        if (lg < 5'(RING_LG_MIN)) begin
            lg_c = 5'(RING_LG_MIN);
        end else if (lg > 5'(RING_LG_MAX)) begin
            lg_c = 5'(RING_LG_MAX);
        end
        return 16'((17'd1 << lg_c) - 17'd1);
    endfunction

endpackage

[hw/rtl/svmc_front.sv]
module svmc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_op,
    input  logic signed [31:0]  i_base_left,
    input  logic signed [31:0]  i_base_right,
    input  logic signed [15:0]  i_sample_value,
    input  logic                i_sample_is_8bit,
    input  logic [7:0]          i_left_volume,
    input  logic [7:0]          i_right_volume,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output svmc_pkg::t_cmd      o_cmd
);
    import svmc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    t_cmd n_cmd;
    logic known_op;
    logic push;
    logic pop;

    // classify and normalize the incoming transaction
    always_comb begin
        known_op = 1'b1;
        n_cmd.op = OP_START;
        unique case (i_op)
            OP_START:  n_cmd.op = OP_START;
            OP_ADD:    n_cmd.op = OP_ADD;
            OP_FINISH: n_cmd.op = OP_FINISH;
            default:   known_op = 1'b0;
        endcase
        n_cmd.base_left  = i_base_left;
        n_cmd.base_right = i_base_right;
        n_cmd.is_8bit    = i_sample_is_8bit;
        if (i_sample_is_8bit) begin
            n_cmd.sample    = {{8{i_sample_value[7]}}, i_sample_value[7:0]};
            n_cmd.vol_left  = {i_left_volume[7:3], 3'b000};
            n_cmd.vol_right = {i_right_volume[7:3], 3'b000};
        end else begin
            n_cmd.sample    = i_sample_value;
            n_cmd.vol_left  = i_left_volume;
            n_cmd.vol_right = i_right_volume;
        end
    end

    assign o_in_ready  = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push        = i_in_valid && o_in_ready && known_op;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_queue[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= n_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not follow push");

endmodule

[hw/rtl/svmc_back.sv]
module svmc_back #(
    parameter int ACC_BITS = svmc_pkg::ACC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  svmc_pkg::t_cfg      i_cfg,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  svmc_pkg::t_cmd      i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_out_sample,
    output logic [15:0]         o_out_index,
    output logic                o_last
);
    import svmc_pkg::*;

    localparam int PROD_W = 25;
    localparam int MIX_W  = 34;
    localparam int CW     = (ACC_BITS > MIX_W) ? ACC_BITS : MIX_W;
    localparam int BW     = (ACC_BITS > 32) ? ACC_BITS : 32;
    localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(SAMPLE_MAX);
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ACC_BITS'(SAMPLE_MIN);

    t_state r_state;
    t_state n_state;
    t_cmd   r_cmd;

    logic signed [PROD_W-1:0]   r_prod_l;
    logic signed [PROD_W-1:0]   r_prod_r;
    logic signed [MIX_W-1:0]    r_mix_l;
    logic signed [MIX_W-1:0]    r_mix_r;
    logic signed [ACC_BITS-1:0] r_acc_l;
    logic signed [ACC_BITS-1:0] r_acc_r;
    logic [15:0]                r_wr_idx;

    logic                r_out_valid;
    logic signed [15:0]  r_out_sample;
    logic [15:0]         r_out_index;
    logic                r_last;

    logic slot_free;
    logic mul_en;
    logic scale_en;
    logic acc_en;
    logic emit_l;
    logic emit_r;
    logic out_load;
    logic [15:0] mask;
    logic signed [MIX_W-1:0] contrib_l;
    logic signed [MIX_W-1:0] contrib_r;
    logic signed [15:0] fin_sample;

    function automatic logic signed [15:0] finish_sample(
        input logic signed [ACC_BITS-1:0] acc,
        input logic                       out8
    );
        logic signed [ACC_BITS-1:0] sh;
        logic signed [15:0]         v;
        sh = acc >>> 8;
        if (sh > SAT_HI) begin
            v = 16'(SAMPLE_MAX);
        end else if (sh < SAT_LO) begin
            v = 16'(SAMPLE_MIN);
        end else begin
            v = sh[15:0];
        end
        if (out8) begin
            v = {8'd0, v[15:8] ^ 8'h80};
        end
        return v;
    endfunction

    assign slot_free = !r_out_valid || i_out_ready;
    assign mask      = ring_mask(i_cfg.ring_size_log2);
    assign out_load  = (emit_l || emit_r) && slot_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_START:  n_state = ST_IDLE;
                        OP_ADD:    n_state = ST_MUL;
                        OP_FINISH: n_state = ST_EMIT_L;
                    endcase
                end
            end
            ST_MUL:   n_state = ST_SCALE;
            ST_SCALE: n_state = ST_ACC;
            ST_ACC:   n_state = ST_IDLE;
            ST_EMIT_L: begin
                if (slot_free) begin
                    n_state = i_cfg.output_stereo ? ST_EMIT_R : ST_IDLE;
                end
            end
            ST_EMIT_R: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd_ready = 1'b0;
        mul_en      = 1'b0;
        scale_en    = 1'b0;
        acc_en      = 1'b0;
        emit_l      = 1'b0;
        emit_r      = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_cmd_ready = 1'b1;
            ST_MUL:    mul_en      = 1'b1;
            ST_SCALE:  scale_en    = 1'b1;
            ST_ACC:    acc_en      = 1'b1;
            ST_EMIT_L: emit_l      = 1'b1;
            ST_EMIT_R: emit_r      = 1'b1;
        endcase
    end

    // 8-bit voices add the full product, 16-bit voices drop 8 fraction bits
    assign contrib_l = r_cmd.is_8bit ? r_mix_l : (r_mix_l >>> 8);
    assign contrib_r = r_cmd.is_8bit ? r_mix_r : (r_mix_r >>> 8);

    assign fin_sample = finish_sample(emit_r ? r_acc_r : r_acc_l, i_cfg.output_8bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc_l     <= '0;
            r_acc_r     <= '0;
            r_wr_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd_ready && i_cmd_valid && (i_cmd.op == OP_START)) begin
                r_acc_l <= ACC_BITS'(BW'(i_cmd.base_left));
                r_acc_r <= ACC_BITS'(BW'(i_cmd.base_right));
            end else if (acc_en) begin
                r_acc_l <= r_acc_l + ACC_BITS'(CW'(contrib_l));
                r_acc_r <= r_acc_r + ACC_BITS'(CW'(contrib_r));
            end
            if (out_load) begin
                r_wr_idx    <= (r_wr_idx + 16'd1) & mask;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_ready && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
        if (mul_en) begin
            r_prod_l <= PROD_W'(r_cmd.sample) * $signed(PROD_W'({1'b0, r_cmd.vol_left}));
            r_prod_r <= PROD_W'(r_cmd.sample) * $signed(PROD_W'({1'b0, r_cmd.vol_right}));
        end
        if (scale_en) begin
            r_mix_l <= MIX_W'(r_prod_l) * $signed(MIX_W'({1'b0, i_cfg.master_volume}));
            r_mix_r <= MIX_W'(r_prod_r) * $signed(MIX_W'({1'b0, i_cfg.master_volume}));
        end
        if (out_load) begin
            r_out_sample <= fin_sample;
            r_out_index  <= r_wr_idx & mask;
            r_last       <= emit_r || !i_cfg.output_stereo;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_out_index  = r_out_index;
    assign o_last       = r_last;

    a_index_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_index & ~mask) == 16'd0))
        else $error("ring index outside ring");

    a_right_only_stereo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_R) |-> i_cfg.output_stereo)
        else $error("right sample in mono mode");

    a_left_then_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_l && slot_free && i_cfg.output_stereo) |=> (r_state == ST_EMIT_R && !r_last))
        else $error("left sample not followed by right");

endmodule

[hw/rtl/stereo_voice_mixer_clip_unit.sv]
// on a finish the back end enters left emit, then registers the first output sample
// start loads the sums, add runs mul/scale/acc, finish emits left then right in stereo
// voice add rate is set by the back sequencer: two registered multiplies, then accumulate
// a 2-entry command queue lets the front accept while the back works or output stalls
// reset (synchronous, active low) clears accumulators, ring index, queue, output valid
// and loads config defaults: master 256, 16-bit output, stereo, ring size log2 14
module stereo_voice_mixer_clip_unit #(
    parameter int ACC_BITS = svmc_pkg::ACC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [svmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [svmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_op,
    input  logic signed [31:0]             i_base_left,
    input  logic signed [31:0]             i_base_right,
    input  logic signed [15:0]             i_sample_value,
    input  logic                           i_sample_is_8bit,
    input  logic [7:0]                     i_left_volume,
    input  logic [7:0]                     i_right_volume,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [15:0]             o_out_sample,
    output logic [15:0]                    o_out_index,
    output logic                           o_last
);
    import svmc_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.master_volume  <= MASTER_VOLUME_RST;
            r_cfg.output_8bit    <= 1'b0;
            r_cfg.output_stereo  <= 1'b1;
            r_cfg.ring_size_log2 <= RING_LG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MASTER_VOLUME:  r_cfg.master_volume  <= i_cfg_data;
                CFG_OUTPUT_8BIT:    r_cfg.output_8bit    <= i_cfg_data[0];
                CFG_OUTPUT_STEREO:  r_cfg.output_stereo  <= i_cfg_data[0];
                CFG_RING_SIZE_LOG2: r_cfg.ring_size_log2 <= i_cfg_data[4:0];
            endcase
        end
    end

    svmc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_base_left      (i_base_left),
        .i_base_right     (i_base_right),
        .i_sample_value   (i_sample_value),
        .i_sample_is_8bit (i_sample_is_8bit),
        .i_left_volume    (i_left_volume),
        .i_right_volume   (i_right_volume),
        .o_cmd_valid      (cmd_valid),
        .i_cmd_ready      (cmd_ready),
        .o_cmd            (cmd)
    );

    svmc_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_ready  (cmd_ready),
        .i_cmd        (cmd),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_sample (o_out_sample),
        .o_out_index  (o_out_index),
        .o_last       (o_last)
    );

endmodule
